>>> design/im2col_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package im2col_pkg;

   // Largest sizes the block handles; register values above them are clamped.
   localparam int MAX_DIM    = 4096;
   localparam int MAX_KERNEL = 32;
   localparam int MAX_BATCH  = 256;
   localparam int MAX_STRIDE = 255;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int SOURCE_W    = 44;
   localparam int COLUMN_W    = 54;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_BATCH_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_WIDTH  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_STRIDE = 3'd6;

   // The output-size division runs one quotient bit per cycle.
   localparam int DIV_STEPS = 12;

   localparam logic AXIS_HEIGHT = 1'b0;
   localparam logic AXIS_WIDTH  = 1'b1;

   // Configuration after clamping, together with the shape check.
   typedef struct packed {
      logic [8:0]  batch_count;
      logic [12:0] image_height;
      logic [12:0] image_width;
      logic [12:0] channel_count;
      logic [5:0]  kernel_height;
      logic [5:0]  kernel_width;
      logic [7:0]  window_stride;
      logic        shape_error;
   } cfg_type;

   typedef struct packed {
      logic div_start;
      logic div_axis;
      logic clear_dirty;
      logic accept;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> design/im2col_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module im2col_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [im2col_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [im2col_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                               clear_dirty,
   output im2col_pkg::cfg_type                     cfg,
   output logic                                    cfg_dirty
);
   import im2col_pkg::*;

   logic [8:0]  batch_count_ff,   batch_count_in;
   logic [12:0] image_height_ff,  image_height_in;
   logic [12:0] image_width_ff,   image_width_in;
   logic [12:0] channel_count_ff, channel_count_in;
   logic [5:0]  kernel_height_ff, kernel_height_in;
   logic [5:0]  kernel_width_ff,  kernel_width_in;
   logic [7:0]  window_stride_ff, window_stride_in;
   logic        dirty_ff,         dirty_in;

   always_comb begin
      batch_count_in   = batch_count_ff;
      image_height_in  = image_height_ff;
      image_width_in   = image_width_ff;
      channel_count_in = channel_count_ff;
      kernel_height_in = kernel_height_ff;
      kernel_width_in  = kernel_width_ff;
      window_stride_in = window_stride_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_BATCH_COUNT:   batch_count_in   = csr_write_data[8:0];
            REG_IMAGE_HEIGHT:  image_height_in  = csr_write_data[12:0];
            REG_IMAGE_WIDTH:   image_width_in   = csr_write_data[12:0];
            REG_CHANNEL_COUNT: channel_count_in = csr_write_data[12:0];
            REG_KERNEL_HEIGHT: kernel_height_in = csr_write_data[5:0];
            REG_KERNEL_WIDTH:  kernel_width_in  = csr_write_data[5:0];
            REG_WINDOW_STRIDE: window_stride_in = csr_write_data[7:0];
            default: ;
         endcase
      end
      // A write that lands together with the clear wins, so it is never missed.
      if (csr_write_enable) begin
         dirty_in = 1'b1;
      end else if (clear_dirty) begin
         dirty_in = 1'b0;
      end else begin
         dirty_in = dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_count_ff   <= 9'd1;
         image_height_ff  <= 13'd1;
         image_width_ff   <= 13'd1;
         channel_count_ff <= 13'd1;
         kernel_height_ff <= 6'd1;
         kernel_width_ff  <= 6'd1;
         window_stride_ff <= 8'd1;
         dirty_ff         <= 1'b1;
      end else begin
         batch_count_ff   <= batch_count_in;
         image_height_ff  <= image_height_in;
         image_width_ff   <= image_width_in;
         channel_count_ff <= channel_count_in;
         kernel_height_ff <= kernel_height_in;
         kernel_width_ff  <= kernel_width_in;
         window_stride_ff <= window_stride_in;
         dirty_ff         <= dirty_in;
      end
   end

   // Zero reads as one, and anything above the supported maximum as the maximum.
   always_comb begin
      if (batch_count_ff == '0) begin
         cfg.batch_count = 9'd1;
      end else if (batch_count_ff > 9'(MAX_BATCH)) begin
         cfg.batch_count = 9'(MAX_BATCH);
      end else begin
         cfg.batch_count = batch_count_ff;
      end

      if (image_height_ff == '0) begin
         cfg.image_height = 13'd1;
      end else if (image_height_ff > 13'(MAX_DIM)) begin
         cfg.image_height = 13'(MAX_DIM);
      end else begin
         cfg.image_height = image_height_ff;
      end

      if (image_width_ff == '0) begin
         cfg.image_width = 13'd1;
      end else if (image_width_ff > 13'(MAX_DIM)) begin
         cfg.image_width = 13'(MAX_DIM);
      end else begin
         cfg.image_width = image_width_ff;
      end

      if (channel_count_ff == '0) begin
         cfg.channel_count = 13'd1;
      end else if (channel_count_ff > 13'(MAX_DIM)) begin
         cfg.channel_count = 13'(MAX_DIM);
      end else begin
         cfg.channel_count = channel_count_ff;
      end

      if (kernel_height_ff == '0) begin
         cfg.kernel_height = 6'd1;
      end else if (kernel_height_ff > 6'(MAX_KERNEL)) begin
         cfg.kernel_height = 6'(MAX_KERNEL);
      end else begin
         cfg.kernel_height = kernel_height_ff;
      end

      if (kernel_width_ff == '0) begin
         cfg.kernel_width = 6'd1;
      end else if (kernel_width_ff > 6'(MAX_KERNEL)) begin
         cfg.kernel_width = 6'(MAX_KERNEL);
      end else begin
         cfg.kernel_width = kernel_width_ff;
      end

      if (window_stride_ff == '0) begin
         cfg.window_stride = 8'd1;
      end else if (window_stride_ff > 8'(MAX_STRIDE)) begin
         cfg.window_stride = 8'(MAX_STRIDE);
      end else begin
         cfg.window_stride = window_stride_ff;
      end

      cfg.shape_error = ({7'd0, cfg.kernel_height} > cfg.image_height)
                        || ({7'd0, cfg.kernel_width} > cfg.image_width);
   end

   assign cfg_dirty = dirty_ff;

endmodule

`default_nettype wire

>>> design/im2col_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module im2col_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [11:0] dividend,
   input  wire logic [7:0]  divisor,
   output logic [11:0]      quotient,
   output logic             done
);
   import im2col_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic              busy_ff,    busy_in;
   logic              done_ff,    done_in;
   logic [STEP_W-1:0] step_ff,    step_in;
   logic [7:0]        rem_ff,     rem_in;
   logic [11:0]       quo_ff,     quo_in;
   logic [7:0]        divisor_ff, divisor_in;
   logic [8:0]        trial;
   logic [8:0]        trial_diff;
   logic              fits;

   // Restoring division: the dividend shifts out at the top of quo_ff while
   // quotient bits shift in at the bottom.
   assign trial      = {rem_ff, quo_ff[11]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign fits       = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_diff[7:0] : trial[7:0];
         quo_in  = {quo_ff[10:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while a division is still running");

endmodule

`default_nettype wire

>>> design/im2col_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module im2col_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire im2col_pkg::cfg_type             cfg,
   input  wire im2col_pkg::ctrl_cmd_type        cmd,
   input  wire logic                            req_restart,
   output im2col_pkg::dp_status_type            status,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [im2col_pkg::SOURCE_W-1:0]      rsp_source_index,
   output logic [im2col_pkg::COLUMN_W-1:0]      rsp_column_index,
   output logic                                 rsp_last,
   output logic                                 rsp_shape_error
);
   import im2col_pkg::*;

   // Walk position.
   logic [7:0]          batch_position_ff,   batch_position_in;
   logic [11:0]         window_row_ff,       window_row_in;
   logic [11:0]         window_column_ff,    window_column_in;
   logic [11:0]         channel_position_ff, channel_position_in;
   logic [4:0]          tap_row_ff,          tap_row_in;
   logic [4:0]          tap_column_ff,       tap_column_in;
   logic [COLUMN_W-1:0] column_counter_ff,   column_counter_in;

   // Output sizes and the division that produces them.
   logic [12:0] out_height_ff, out_height_in;
   logic [12:0] out_width_ff,  out_width_in;
   logic        div_axis_ff,   div_axis_in;
   logic [12:0] height_span;
   logic [12:0] width_span;
   logic [11:0] div_dividend;
   logic [11:0] div_quotient;
   logic        div_done;

   // Address arithmetic, at most one multiplication in series per stage.
   logic [19:0] row_scaled;
   logic [19:0] column_scaled;
   logic [19:0] tap_y_ff,      tap_y_in;
   logic [19:0] tap_x_ff,      tap_x_in;
   logic [20:0] batch_base_ff, batch_base_in;
   logic [21:0] image_row_ff,  image_row_in;
   logic [34:0] row_scan;
   logic [35:0] pixel_ff,      pixel_in;
   logic [48:0] pixel_scan;
   logic [SOURCE_W-1:0] source_index;

   // Carry chain of the nested counters.
   logic [5:0]  tap_column_next;
   logic [5:0]  tap_row_next;
   logic [12:0] channel_next;
   logic [12:0] window_column_next;
   logic [12:0] window_row_next;
   logic [8:0]  batch_next;
   logic        tap_column_end;
   logic        tap_row_end;
   logic        channel_end;
   logic        window_column_end;
   logic        window_row_end;
   logic        batch_end;
   logic        carry_tap_row;
   logic        carry_channel;
   logic        carry_window_column;
   logic        carry_window_row;
   logic        carry_batch;
   logic        wrap_all;
   logic        advance;

   logic                rsp_valid_ff,        rsp_valid_in;
   logic [SOURCE_W-1:0] rsp_source_index_ff, rsp_source_index_in;
   logic [COLUMN_W-1:0] rsp_column_index_ff, rsp_column_index_in;
   logic                rsp_last_ff,         rsp_last_in;
   logic                rsp_shape_error_ff,  rsp_shape_error_in;

   // ---------------------------------------------------------------- sizes
   assign height_span = (cfg.image_height >= {7'd0, cfg.kernel_height})
                        ? cfg.image_height - {7'd0, cfg.kernel_height} : '0;
   assign width_span  = (cfg.image_width >= {7'd0, cfg.kernel_width})
                        ? cfg.image_width - {7'd0, cfg.kernel_width} : '0;
   assign div_dividend = (cmd.div_axis == AXIS_WIDTH) ? width_span[11:0]
                                                      : height_span[11:0];

   im2col_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (cfg.window_stride),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      div_axis_in   = cmd.div_start ? cmd.div_axis : div_axis_ff;
      out_height_in = out_height_ff;
      out_width_in  = out_width_ff;
      if (div_done) begin
         if (div_axis_ff == AXIS_WIDTH) begin
            out_width_in = {1'b0, div_quotient} + 13'd1;
         end else begin
            out_height_in = {1'b0, div_quotient} + 13'd1;
         end
      end
   end

   // ------------------------------------------------------ address stages
   assign row_scaled    = {8'd0, window_row_ff} * {12'd0, cfg.window_stride};
   assign column_scaled = {8'd0, window_column_ff} * {12'd0, cfg.window_stride};
   assign tap_y_in      = row_scaled + {15'd0, tap_row_ff};
   assign tap_x_in      = column_scaled + {15'd0, tap_column_ff};
   assign batch_base_in = {13'd0, batch_position_ff} * {8'd0, cfg.image_height};
   assign image_row_in  = {1'b0, batch_base_ff} + {2'd0, tap_y_ff};
   assign row_scan      = {13'd0, image_row_ff} * {22'd0, cfg.image_width};
   assign pixel_in      = {1'b0, row_scan} + {16'd0, tap_x_ff};
   assign pixel_scan    = {13'd0, pixel_ff} * {36'd0, cfg.channel_count};
   assign source_index  = pixel_scan[SOURCE_W-1:0]
                          + {{(SOURCE_W-12){1'b0}}, channel_position_ff};

   // ------------------------------------------------------------ counters
   assign tap_column_next    = {1'b0, tap_column_ff} + 6'd1;
   assign tap_row_next       = {1'b0, tap_row_ff} + 6'd1;
   assign channel_next       = {1'b0, channel_position_ff} + 13'd1;
   assign window_column_next = {1'b0, window_column_ff} + 13'd1;
   assign window_row_next    = {1'b0, window_row_ff} + 13'd1;
   assign batch_next         = {1'b0, batch_position_ff} + 9'd1;

   // A counter whose next value reaches or passes its bound counts as finished.
   assign tap_column_end    = tap_column_next >= cfg.kernel_width;
   assign tap_row_end       = tap_row_next >= cfg.kernel_height;
   assign channel_end       = channel_next >= cfg.channel_count;
   assign window_column_end = window_column_next >= out_width_ff;
   assign window_row_end    = window_row_next >= out_height_ff;
   assign batch_end         = batch_next >= cfg.batch_count;

   assign carry_tap_row       = tap_column_end;
   assign carry_channel       = carry_tap_row && tap_row_end;
   assign carry_window_column = carry_channel && channel_end;
   assign carry_window_row    = carry_window_column && window_column_end;
   assign carry_batch         = carry_window_row && window_row_end;
   assign wrap_all            = carry_batch && batch_end;

   assign advance = cmd.load && !cfg.shape_error;

   always_comb begin
      batch_position_in   = batch_position_ff;
      window_row_in       = window_row_ff;
      window_column_in    = window_column_ff;
      channel_position_in = channel_position_ff;
      tap_row_in          = tap_row_ff;
      tap_column_in       = tap_column_ff;
      column_counter_in   = column_counter_ff;
      if (cmd.accept && req_restart) begin
         batch_position_in   = '0;
         window_row_in       = '0;
         window_column_in    = '0;
         channel_position_in = '0;
         tap_row_in          = '0;
         tap_column_in       = '0;
         column_counter_in   = '0;
      end else if (advance) begin
         tap_column_in = tap_column_end ? '0 : tap_column_next[4:0];
         if (carry_tap_row) begin
            tap_row_in = tap_row_end ? '0 : tap_row_next[4:0];
         end
         if (carry_channel) begin
            channel_position_in = channel_end ? '0 : channel_next[11:0];
         end
         if (carry_window_column) begin
            window_column_in = window_column_end ? '0 : window_column_next[11:0];
         end
         if (carry_window_row) begin
            window_row_in = window_row_end ? '0 : window_row_next[11:0];
         end
         if (carry_batch) begin
            batch_position_in = batch_end ? '0 : batch_next[7:0];
         end
         column_counter_in = wrap_all ? '0 : column_counter_ff + 1'b1;
      end
   end

   // -------------------------------------------------------- result beat
   always_comb begin
      rsp_source_index_in = rsp_source_index_ff;
      rsp_column_index_in = rsp_column_index_ff;
      rsp_last_in         = rsp_last_ff;
      rsp_shape_error_in  = rsp_shape_error_ff;
      if (cmd.load) begin
         rsp_shape_error_in = cfg.shape_error;
         if (cfg.shape_error) begin
            rsp_source_index_in = '0;
            rsp_column_index_in = '0;
            rsp_last_in         = 1'b0;
         end else begin
            rsp_source_index_in = source_index;
            rsp_column_index_in = column_counter_ff;
            rsp_last_in         = wrap_all;
         end
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_position_ff   <= '0;
         window_row_ff       <= '0;
         window_column_ff    <= '0;
         channel_position_ff <= '0;
         tap_row_ff          <= '0;
         tap_column_ff       <= '0;
         column_counter_ff   <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         batch_position_ff   <= batch_position_in;
         window_row_ff       <= window_row_in;
         window_column_ff    <= window_column_in;
         channel_position_ff <= channel_position_in;
         tap_row_ff          <= tap_row_in;
         tap_column_ff       <= tap_column_in;
         column_counter_ff   <= column_counter_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_axis_ff         <= div_axis_in;
      out_height_ff       <= out_height_in;
      out_width_ff        <= out_width_in;
      tap_y_ff            <= tap_y_in;
      tap_x_ff            <= tap_x_in;
      batch_base_ff       <= batch_base_in;
      image_row_ff        <= image_row_in;
      pixel_ff            <= pixel_in;
      rsp_source_index_ff <= rsp_source_index_in;
      rsp_column_index_ff <= rsp_column_index_in;
      rsp_last_ff         <= rsp_last_in;
      rsp_shape_error_ff  <= rsp_shape_error_in;
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_source_index = rsp_source_index_ff;
   assign rsp_column_index = rsp_column_index_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_shape_error  = rsp_shape_error_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a beat that has not been taken");

   assert property (@(posedge clock) disable iff (reset)
      (!cmd.load && !cmd.accept) |=> $stable(column_counter_ff) && $stable(tap_column_ff))
      else $error("walk position moved without an accepted or finished item");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_shape_error_ff)
      |-> (rsp_source_index_ff == '0 && rsp_column_index_ff == '0 && !rsp_last_ff))
      else $error("shape error beat carries non-zero indices");

endmodule

`default_nettype wire

>>> design/im2col_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module im2col_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       cfg_dirty,
   input  wire im2col_pkg::dp_status_type  status,
   output im2col_pkg::ctrl_cmd_type        cmd
);
   import im2col_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV_H  = 3'd1;
   localparam logic [2:0] ST_DIV_W  = 3'd2;
   localparam logic [2:0] ST_CALC1  = 3'd3;
   localparam logic [2:0] ST_CALC2  = 3'd4;
   localparam logic [2:0] ST_CALC3  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cfg_dirty) begin
               cmd.div_start   = 1'b1;
               cmd.div_axis    = AXIS_HEIGHT;
               cmd.clear_dirty = 1'b1;
               state_in        = ST_DIV_H;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = ST_CALC1;
               end
            end
         end
         ST_DIV_H: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_axis  = AXIS_WIDTH;
               state_in      = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            if (status.div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_CALC1: state_in = ST_CALC2;
         ST_CALC2: state_in = ST_CALC3;
         ST_CALC3: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> ##2 (state_ff == ST_CALC3))
      else $error("accepted item did not reach the last address stage in time");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !status.out_free) |=> (state_ff == ST_FINISH))
      else $error("finished item dropped while the result register was full");

endmodule

`default_nettype wire

>>> design/im2col_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// im2col address generator for NHWC images without padding. Each accepted
// request beat yields one response beat holding the flat source index to read
// and the column-buffer index to write; the walk runs over batch, output row,
// output column, channel, kernel row and kernel column, the last of these
// innermost, and wraps to the start after the final element (flagged by
// rsp_last). A request with req_restart set returns to element zero first.
// If a kernel dimension exceeds the image, the response carries
// rsp_shape_error with zero indices and the walk does not move. Register
// values of zero read as one, and sizes above the supported maxima are
// clamped. After a request beat is accepted, it passes through the address
// chain before its response is loaded: the window scaling and batch offset
// products side by side, the image row sum, the row times the image width,
// and the pixel times the channel count. Each stage holds at most one
// multiplication in series, and a new request beat is accepted only after
// the previous one has been loaded. A finished response waits in an output
// register, so the next request is accepted while the previous response is
// still pending; if that response has still not been taken when the next
// one is finished, the sequencer holds in its last stage and req_ready
// stays low. After reset, and after any configuration write, the output
// sizes are recomputed by a one-bit-per-cycle divider, once per axis, and
// req_ready stays low during this recomputation.
// Configuration writes take effect at once and should only be made while no
// request is in progress.
module im2col_address_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_restart,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [im2col_pkg::SOURCE_W-1:0]         rsp_source_index,
   output logic [im2col_pkg::COLUMN_W-1:0]         rsp_column_index,
   output logic                                    rsp_last,
   output logic                                    rsp_shape_error,

   input  wire logic                               csr_write_enable,
   input  wire logic [im2col_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [im2col_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import im2col_pkg::*;

   cfg_type       cfg;
   logic          cfg_dirty;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Register file, clamping and the shape check.
   im2col_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .clear_dirty      (cmd.clear_dirty),
      .cfg              (cfg),
      .cfg_dirty        (cfg_dirty)
   );

   // Sequencer: size recomputation, then one request beat at a time.
   im2col_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cfg_dirty (cfg_dirty),
      .status    (status),
      .cmd       (cmd)
   );

   // Walk counters, address arithmetic and the response register.
   im2col_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .req_restart      (req_restart),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_source_index (rsp_source_index),
      .rsp_column_index (rsp_column_index),
      .rsp_last         (rsp_last),
      .rsp_shape_error  (rsp_shape_error)
   );

endmodule

`default_nettype wire
